// ----- hdl/tlnf_pkg.sv -----
// shared types and constants for the text line number filter
package tlnf_pkg;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_ALL       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_ENDS        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_NEWLINE  = 8'd10;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_DOLLAR   = 8'd36;
    localparam logic [7:0] CH_ZERO     = 8'd48;
    localparam logic [7:0] CH_QMARK    = 8'd63;
    localparam logic [7:0] CH_I        = 8'd73;
    localparam logic [7:0] CH_CARET    = 8'd94;
    localparam logic [7:0] CH_DEL      = 8'd127;
    localparam logic [7:0] CTRL_LIMIT  = 8'd31;
    localparam logic [7:0] CTRL_OFFSET = 8'd64;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } cfg_t;

    typedef struct packed {
        logic drop;
        logic emit_number;
    } line_info_t;

endpackage

// ----- hdl/tlnf_in_if.sv -----
// request channel carrying one text byte
interface tlnf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;

    modport source (output valid, output data_byte, output file_start, input ready);
    modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

// ----- hdl/tlnf_out_if.sv -----
// request channel carrying one rendered byte
interface tlnf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- hdl/tlnf_cfg_if.sv -----
// configuration write channel
interface tlnf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tlnf_pkg::CFG_INDEX_W-1:0] index;
    logic                             data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/tlnf_track.sv -----
// line state tracking: newline runs, squeeze decision and bcd line counters
module tlnf_track #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [7:0]                 data_byte,
    input  logic                       file_start,
    input  tlnf_pkg::cfg_t             cfg,
    output tlnf_pkg::line_info_t       info,
    output logic [4*NUMBER_DIGITS-1:0] number
);

    localparam int CW = 4 * NUMBER_DIGITS;

    function automatic logic [CW-1:0] bcd_inc(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        logic          carry;
        logic          all_nine;
        r        = v;
        carry    = 1'b1;
        all_nine = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            all_nine = all_nine && (v[4*i +: 4] == 4'd9);
        end
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (carry)
            begin
                if (v[4*i +: 4] == 4'd9)
                begin
                    r[4*i +: 4] = 4'd0;
                end
                else
                begin
                    r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return all_nine ? v : r;
    endfunction

    logic          prev_nl_reg, prev_nl_next;
    logic [1:0]    run_reg, run_next;
    logic [CW-1:0] line_cnt_reg, line_cnt_next;
    logic [CW-1:0] nb_cnt_reg, nb_cnt_next;

    logic          pwn;
    logic [1:0]    run0;
    logic [CW-1:0] lc0;
    logic [CW-1:0] nb0;
    logic          nl;
    logic          at_start;

    always_comb
    begin
        pwn  = file_start ? 1'b1 : prev_nl_reg;
        run0 = file_start ? 2'd0 : run_reg;
        lc0  = file_start ? '0 : line_cnt_reg;
        nb0  = file_start ? CW'(1) : nb_cnt_reg;
        nl   = (data_byte == tlnf_pkg::CH_NEWLINE);

        if (nl)
        begin
            run_next = (run0 == 2'd3) ? 2'd3 : run0 + 2'd1;
        end
        else
        begin
            run_next = 2'd0;
        end

        info.drop = nl && cfg.squeeze_blank && (run_next == 2'd3);
        at_start  = pwn && !info.drop;

        line_cnt_next    = at_start ? bcd_inc(lc0) : lc0;
        info.emit_number = at_start && (cfg.number_nonblank ? !nl : cfg.number_all);
        number           = cfg.number_nonblank ? nb0 : line_cnt_next;
        nb_cnt_next      = (at_start && cfg.number_nonblank && !nl) ? bcd_inc(nb0) : nb0;
        prev_nl_next     = info.drop ? pwn : nl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_nl_reg  <= 1'b1;
            run_reg      <= 2'd0;
            line_cnt_reg <= '0;
            nb_cnt_reg   <= CW'(1);
        end
        else if (advance)
        begin
            prev_nl_reg  <= prev_nl_next;
            run_reg      <= run_next;
            line_cnt_reg <= line_cnt_next;
            nb_cnt_reg   <= nb_cnt_next;
        end
    end

endmodule

// ----- hdl/tlnf_render.sv -----
// byte rendering: line number, end mark and caret notation into output lanes
module tlnf_render #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic [7:0]                                       data_byte,
    input  tlnf_pkg::cfg_t                                   cfg,
    input  logic                                             emit_number,
    input  logic [4*NUMBER_DIGITS-1:0]                       number,
    output logic [NUMBER_DIGITS+2:0][7:0]                    lanes,
    output logic [$clog2(NUMBER_DIGITS+3)-1:0]               last_idx
);

    localparam int DEPTH = NUMBER_DIGITS + 3;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = 4 * NUMBER_DIGITS;

    logic [7:0] ch0;
    logic [7:0] ch1;
    logic       ch_two;
    logic [NUMBER_DIGITS-1:0][7:0] digit_ch;

    always_comb
    begin
        ch0    = data_byte;
        ch1    = 8'd0;
        ch_two = 1'b0;
        if (data_byte == tlnf_pkg::CH_NEWLINE)
        begin
            if (cfg.show_ends)
            begin
                ch0    = tlnf_pkg::CH_DOLLAR;
                ch1    = tlnf_pkg::CH_NEWLINE;
                ch_two = 1'b1;
            end
        end
        else if (data_byte == tlnf_pkg::CH_TAB)
        begin
            if (cfg.show_tabs)
            begin
                ch0    = tlnf_pkg::CH_CARET;
                ch1    = tlnf_pkg::CH_I;
                ch_two = 1'b1;
            end
        end
        else if (cfg.show_nonprinting && data_byte <= tlnf_pkg::CTRL_LIMIT)
        begin
            ch0    = tlnf_pkg::CH_CARET;
            ch1    = data_byte + tlnf_pkg::CTRL_OFFSET;
            ch_two = 1'b1;
        end
        else if (cfg.show_nonprinting && data_byte == tlnf_pkg::CH_DEL)
        begin
            ch0    = tlnf_pkg::CH_CARET;
            ch1    = tlnf_pkg::CH_QMARK;
            ch_two = 1'b1;
        end
    end

    // leading zeros blanked, units digit always shown
    always_comb
    begin
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (i > 0 && (number >> (4 * i)) == CW'(0))
            begin
                digit_ch[i] = tlnf_pkg::CH_SPACE;
            end
            else
            begin
                digit_ch[i] = tlnf_pkg::CH_ZERO | {4'd0, number[4*i +: 4]};
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            lanes[k] = 8'd0;
            if (emit_number)
            begin
                if (k < NUMBER_DIGITS)
                begin
                    lanes[k] = digit_ch[NUMBER_DIGITS-1-k];
                end
                else if (k == NUMBER_DIGITS)
                begin
                    lanes[k] = tlnf_pkg::CH_TAB;
                end
                else if (k == NUMBER_DIGITS + 1)
                begin
                    lanes[k] = ch0;
                end
                else
                begin
                    lanes[k] = ch1;
                end
            end
            else if (k == 0)
            begin
                lanes[k] = ch0;
            end
            else if (k == 1)
            begin
                lanes[k] = ch1;
            end
        end
        last_idx = emit_number ? IW'(NUMBER_DIGITS + 1) + IW'(ch_two) : IW'(ch_two);
    end

endmodule

// ----- hdl/tlnf_drain.sv -----
// output buffer that sends one rendered run a byte at a time
module tlnf_drain #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic [NUMBER_DIGITS+2:0][7:0]        load_lanes,
    input  logic [$clog2(NUMBER_DIGITS+3)-1:0]   load_last,
    output logic                                 can_load,
    tlnf_out_if.source                           rendered
);

    localparam int DEPTH = NUMBER_DIGITS + 3;
    localparam int IW    = $clog2(DEPTH);

    logic                  busy_reg, busy_next;
    logic [IW-1:0]         pos_reg, pos_next;
    logic [IW-1:0]         last_reg, last_next;
    logic [DEPTH-1:0][7:0] lanes_reg, lanes_next;
    logic                  fire;
    logic                  at_last;

    assign fire     = busy_reg && rendered.ready;
    assign at_last  = (pos_reg == last_reg);
    assign can_load = !busy_reg || (rendered.ready && at_last);

    always_comb
    begin
        busy_next  = busy_reg;
        pos_next   = pos_reg;
        last_next  = last_reg;
        lanes_next = lanes_reg;
        if (fire)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + IW'(1);
            end
        end
        if (load)
        begin
            busy_next  = 1'b1;
            pos_next   = '0;
            last_next  = load_last;
            lanes_next = load_lanes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        lanes_reg <= lanes_next;
    end

    assign rendered.valid       = busy_reg;
    assign rendered.out_byte    = lanes_reg[pos_reg];
    assign rendered.last_of_run = at_last;

    a_pos_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pos_reg <= last_reg)
        else $error("drain position beyond run end");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !at_last && !load |=> busy_reg && pos_reg == $past(pos_reg) + IW'(1))
        else $error("drain position did not advance by one");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(fire && at_last))
        else $error("drain went idle before the last byte was taken");

endmodule

// ----- hdl/text_line_number_filter.sv -----
// top level of the text line number filter: input register, config registers, core
// Each request carries one text byte and yields zero to NUMBER_DIGITS+3 rendered bytes on the
// output channel, the final one flagged by last_of_run. Plain text streams at one byte per
// cycle while the output side takes every byte; a byte rendered as several bytes holds the
// input until the output buffer, sending one byte per cycle unless stalled, has sent the
// run (NUMBER_DIGITS+1 extra for a numbered line start, one extra for a caret or end mark).
// A squeezed newline yields nothing and leaves the input register as soon as the output
// buffer can take a new run. A request passes the input register and then the output
// buffer before its first byte is valid. Configuration writes are taken at any time
// but should be made only while the block is idle.
module text_line_number_filter #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    tlnf_in_if.sink    text,
    tlnf_out_if.source rendered,
    tlnf_cfg_if.sink   cfg
);

    localparam int DEPTH = NUMBER_DIGITS + 3;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = 4 * NUMBER_DIGITS;

    tlnf_pkg::cfg_t       cfg_reg;
    logic                 s1_valid_reg;
    logic [7:0]           s1_byte_reg;
    logic                 s1_start_reg;
    logic                 advance;
    logic                 can_load;
    tlnf_pkg::line_info_t info;
    logic [CW-1:0]        number;
    logic [DEPTH-1:0][7:0] lanes;
    logic [IW-1:0]        last_idx;

    assign cfg.ready  = 1'b1;
    assign advance    = s1_valid_reg && can_load;
    assign text.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tlnf_pkg::CFG_NUMBER_ALL:       cfg_reg.number_all       <= cfg.data;
                tlnf_pkg::CFG_NUMBER_NONBLANK:  cfg_reg.number_nonblank  <= cfg.data;
                tlnf_pkg::CFG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= cfg.data;
                tlnf_pkg::CFG_SHOW_ENDS:        cfg_reg.show_ends        <= cfg.data;
                tlnf_pkg::CFG_SHOW_TABS:        cfg_reg.show_tabs        <= cfg.data;
                tlnf_pkg::CFG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (text.valid && text.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            s1_byte_reg  <= text.data_byte;
            s1_start_reg <= text.file_start;
        end
    end

    tlnf_track #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .data_byte  (s1_byte_reg),
        .file_start (s1_start_reg),
        .cfg        (cfg_reg),
        .info       (info),
        .number     (number)
    );

    tlnf_render #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_render (
        .data_byte   (s1_byte_reg),
        .cfg         (cfg_reg),
        .emit_number (info.emit_number),
        .number      (number),
        .lanes       (lanes),
        .last_idx    (last_idx)
    );

    tlnf_drain #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_drain (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && !info.drop),
        .load_lanes (lanes),
        .load_last  (last_idx),
        .can_load   (can_load),
        .rendered   (rendered)
    );

endmodule

// ----- bench/text_line_number_filter_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for the text line number filter: rendering scoreboard, stream drivers
module text_line_number_filter_tb;

    localparam int DIGITS = 6;
    localparam int COUNT_W = 4 * DIGITS;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT = 17;
    localparam int FILE_START_PCT = 4;
    localparam int REPORT_LIMIT = 10;
    localparam logic [tlnf_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [tlnf_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } rendered_t;

    class render_scoreboard;
        tlnf_pkg::cfg_t     settings;
        logic               at_line_start;
        logic [1:0]         newline_streak;
        logic [COUNT_W-1:0] lines_seen;
        logic [COUNT_W-1:0] nonblank_seen;
        rendered_t          expected_bytes[$];
        logic [7:0]         run_bytes[$];
        int                 mismatches;

        function new();
            settings = '0;
            mismatches = 0;
            restart_file();
        endfunction

        function void restart_file();
            at_line_start = 1'b1;
            newline_streak = 2'd0;
            lines_seen = '0;
            nonblank_seen = COUNT_W'(1);
        endfunction

        function void write_reg(logic [tlnf_pkg::CFG_INDEX_W-1:0] idx, logic val);
            case (idx)
                tlnf_pkg::CFG_NUMBER_ALL:       settings.number_all = val;
                tlnf_pkg::CFG_NUMBER_NONBLANK:  settings.number_nonblank = val;
                tlnf_pkg::CFG_SQUEEZE_BLANK:    settings.squeeze_blank = val;
                tlnf_pkg::CFG_SHOW_ENDS:        settings.show_ends = val;
                tlnf_pkg::CFG_SHOW_TABS:        settings.show_tabs = val;
                tlnf_pkg::CFG_SHOW_NONPRINTING: settings.show_nonprinting = val;
                default: ;
            endcase
        endfunction

        // decimal counter step, holding at all nines
        function logic [COUNT_W-1:0] bcd_next(logic [COUNT_W-1:0] v);
            logic [COUNT_W-1:0] nines;
            logic [COUNT_W-1:0] r;
            int i;
            nines = '0;
            for (i = 0; i < DIGITS; i++)
                nines[4*i +: 4] = 4'd9;
            if (v == nines)
                return v;
            r = v;
            for (i = 0; i < DIGITS; i++)
            begin
                if (r[4*i +: 4] < 4'd9)
                begin
                    r[4*i +: 4] = r[4*i +: 4] + 4'd1;
                    return r;
                end
                r[4*i +: 4] = 4'd0;
            end
            return r;
        endfunction

        function void push_number(logic [COUNT_W-1:0] v);
            int i;
            logic seen;
            logic [3:0] d;
            seen = 1'b0;
            for (i = DIGITS - 1; i >= 0; i--)
            begin
                d = v[4*i +: 4];
                if (d == 4'd0 && !seen && i > 0)
                    run_bytes.push_back(tlnf_pkg::CH_SPACE);
                else
                begin
                    seen = 1'b1;
                    run_bytes.push_back(tlnf_pkg::CH_ZERO + {4'd0, d});
                end
            end
            run_bytes.push_back(tlnf_pkg::CH_TAB);
        endfunction

        function void note_request(logic [7:0] c, logic first);
            logic is_nl;
            int i;
            is_nl = (c == tlnf_pkg::CH_NEWLINE);
            run_bytes.delete();
            if (first)
                restart_file();
            if (is_nl)
            begin
                if (newline_streak != 2'd3)
                    newline_streak = newline_streak + 2'd1;
            end
            else
                newline_streak = 2'd0;
            // squeezed newline: dropped, line state untouched
            if (is_nl && settings.squeeze_blank && newline_streak == 2'd3)
                return;
            if (at_line_start)
            begin
                lines_seen = bcd_next(lines_seen);
                if (settings.number_nonblank)
                begin
                    if (!is_nl)
                    begin
                        push_number(nonblank_seen);
                        nonblank_seen = bcd_next(nonblank_seen);
                    end
                end
                else if (settings.number_all)
                    push_number(lines_seen);
            end
            if (is_nl)
            begin
                if (settings.show_ends)
                    run_bytes.push_back(tlnf_pkg::CH_DOLLAR);
                run_bytes.push_back(c);
            end
            else if (c == tlnf_pkg::CH_TAB)
            begin
                if (settings.show_tabs)
                begin
                    run_bytes.push_back(tlnf_pkg::CH_CARET);
                    run_bytes.push_back(tlnf_pkg::CH_I);
                end
                else
                    run_bytes.push_back(c);
            end
            else if (settings.show_nonprinting && c <= tlnf_pkg::CTRL_LIMIT)
            begin
                run_bytes.push_back(tlnf_pkg::CH_CARET);
                run_bytes.push_back(c + tlnf_pkg::CTRL_OFFSET);
            end
            else if (settings.show_nonprinting && c == tlnf_pkg::CH_DEL)
            begin
                run_bytes.push_back(tlnf_pkg::CH_CARET);
                run_bytes.push_back(tlnf_pkg::CH_QMARK);
            end
            else
                run_bytes.push_back(c);
            at_line_start = is_nl;
            for (i = 0; i < run_bytes.size(); i++)
                expected_bytes.push_back('{out_byte: run_bytes[i],
                                           last_of_run: (i == run_bytes.size() - 1)});
        endfunction

        function void check_result(logic [7:0] b, logic last);
            rendered_t want;
            if (expected_bytes.size() == 0)
            begin
                flag($sformatf("unexpected byte %h last %b", b, last));
                return;
            end
            want = expected_bytes.pop_front();
            if (want.out_byte !== b || want.last_of_run !== last)
                flag($sformatf("expected byte %h last %b, got byte %h last %b",
                               want.out_byte, want.last_of_run, b, last));
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch: %s", msg);
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void close_out();
            if (expected_bytes.size() != 0)
                flag($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic idling;
    int   stall_cycles = 0;
    render_scoreboard sb;

    tlnf_in_if  text_ch();
    tlnf_out_if rend_ch();
    tlnf_cfg_if cfg_ch();

    text_line_number_filter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text_ch),
        .rendered (rend_ch),
        .cfg      (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        if (!rst_n)
            rend_ch.ready <= 1'b0;
        else
            rend_ch.ready <= !(idling && $urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        logic moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (rend_ch.valid && rend_ch.ready)
            begin
                sb.check_result(rend_ch.out_byte, rend_ch.last_of_run);
                moved = 1'b1;
            end
            if (text_ch.valid && text_ch.ready)
            begin
                sb.note_request(text_ch.data_byte, text_ch.file_start);
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                sb.write_reg(cfg_ch.index, cfg_ch.data);
                moved = 1'b1;
            end
            if (moved)
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        while (idling && $urandom_range(0, 99) < IDLE_PCT)
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid <= 1'b1;
        text_ch.data_byte <= b;
        text_ch.file_start <= first;
        do
            @(posedge clk);
        while (!text_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_settings(input tlnf_pkg::cfg_t s, input logic probe_unmapped);
        logic [tlnf_pkg::CFG_INDEX_W-1:0] idx[$];
        logic                             val[$];
        int                               i;
        idx.push_back(tlnf_pkg::CFG_NUMBER_ALL);       val.push_back(s.number_all);
        idx.push_back(tlnf_pkg::CFG_NUMBER_NONBLANK);  val.push_back(s.number_nonblank);
        idx.push_back(tlnf_pkg::CFG_SQUEEZE_BLANK);    val.push_back(s.squeeze_blank);
        idx.push_back(tlnf_pkg::CFG_SHOW_ENDS);        val.push_back(s.show_ends);
        idx.push_back(tlnf_pkg::CFG_SHOW_TABS);        val.push_back(s.show_tabs);
        idx.push_back(tlnf_pkg::CFG_SHOW_NONPRINTING); val.push_back(s.show_nonprinting);
        // writes past the last register must leave everything alone
        if (probe_unmapped)
        begin
            idx.push_back(CFG_UNMAPPED_LO); val.push_back(~s.number_all);
            idx.push_back(CFG_UNMAPPED_HI); val.push_back(~s.show_nonprinting);
        end
        cfg_ch.valid <= 1'b1;
        for (i = 0; i < idx.size(); i++)
        begin
            cfg_ch.index <= idx[i];
            cfg_ch.data <= val[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'($urandom_range(32, 126));
        else if (r < 60)
            return tlnf_pkg::CH_NEWLINE;
        else if (r < 68)
            return tlnf_pkg::CH_TAB;
        else if (r < 83)
            return 8'($urandom_range(0, 31));
        else if (r < 88)
            return tlnf_pkg::CH_DEL;
        else
            return 8'($urandom_range(128, 255));
    endfunction

    task automatic run_random(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            // hold off once until the output side has caught up
            if (i == count / 2)
                wait_drained();
            send_byte(pick_text_byte(), $urandom_range(0, 99) < FILE_START_PCT);
        end
    endtask

    initial
    begin
        tlnf_pkg::cfg_t s;
        int             phase;
        sb = new();
        rst_n = 1'b0;
        idling = 1'b1;
        text_ch.valid = 1'b0;
        text_ch.data_byte = 8'd0;
        text_ch.file_start = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = tlnf_pkg::CFG_NUMBER_ALL;
        cfg_ch.data = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every mode on, nonblank numbering wins
        s = '1;
        write_settings(s, 1'b1);
        send_byte(8'h41, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h1f, 1'b0);
        send_byte(tlnf_pkg::CH_DEL, 1'b0);
        send_byte(tlnf_pkg::CH_TAB, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(tlnf_pkg::CH_NEWLINE, 1'b0);
        send_byte(tlnf_pkg::CH_NEWLINE, 1'b0);
        send_byte(tlnf_pkg::CH_NEWLINE, 1'b0);
        send_byte(tlnf_pkg::CH_NEWLINE, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'h0b, 1'b0);
        send_byte(tlnf_pkg::CH_NEWLINE, 1'b0);
        send_byte(tlnf_pkg::CH_NEWLINE, 1'b1);
        send_byte(8'h7e, 1'b0);
        send_byte(tlnf_pkg::CH_NEWLINE, 1'b0);
        settle();

        // plain numbering of every line, blank ones too
        s = '0;
        s.number_all = 1'b1;
        write_settings(s, 1'b0);
        send_byte(tlnf_pkg::CH_NEWLINE, 1'b0);
        send_byte(tlnf_pkg::CH_NEWLINE, 1'b0);
        send_byte(tlnf_pkg::CH_NEWLINE, 1'b0);
        send_byte(8'h7a, 1'b0);
        send_byte(tlnf_pkg::CH_TAB, 1'b0);
        send_byte(tlnf_pkg::CH_NEWLINE, 1'b0);
        settle();

        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                s = '0;
            else if (phase == 1)
                s = '1;
            else
                s = 6'($urandom_range(0, 63));
            idling = (phase != 1);
            write_settings(s, 1'b0);
            run_random(26);
            settle();
        end

        sb.close_out();
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
